### hdl/epd_pkg.sv
// Shared types, codes and the grayscale waveform table for the e-paper drive encoder.
package epd_pkg;

   // Operating modes carried with each pixel transfer.
   typedef enum logic [2:0] {
      MODE_BLACK     = 3'd0,
      MODE_BW        = 3'd1,
      MODE_DISCHARGE = 3'd2,
      MODE_PARTIAL   = 3'd3,
      MODE_GRAY      = 3'd4
   } mode_type;

   // Two-bit panel drive codes.
   localparam logic [1:0] CODE_DISCHARGE = 2'b00;
   localparam logic [1:0] CODE_BLACK     = 2'b01;
   localparam logic [1:0] CODE_WHITE     = 2'b10;
   localparam logic [1:0] CODE_HOLD      = 2'b11;

   localparam int GRAY_LEVELS = 8;
   localparam int GRAY_PHASES = 9;
   localparam logic [3:0] LAST_PHASE = 4'(GRAY_PHASES - 1);

   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   // Drive code for each gray level (row) at each waveform phase (column).
   localparam logic [1:0] GRAY_WAVE [GRAY_LEVELS][GRAY_PHASES] = '{
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0},
      '{2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0},
      '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0},
      '{2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0},
      '{2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0},
      '{2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0},
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0}
   };

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [3:0] phase;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] drive_first;
      logic [7:0] drive_second;
      logic [1:0] bytes_valid;
      logic       phase_error;
   } rsp_payload_type;

endpackage

### hdl/epd_channels.sv
// Valid/ready channel interfaces for pixel requests and drive responses.
interface epd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic [3:0] phase;

   modport source (output valid, mode, first_byte, second_byte, phase, input ready);
   modport sink   (input valid, mode, first_byte, second_byte, phase, output ready);
endinterface

interface epd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] drive_first;
   logic [7:0] drive_second;
   logic [1:0] bytes_valid;
   logic       phase_error;

   modport source (output valid, drive_first, drive_second, bytes_valid, phase_error,
                   input ready);
   modport sink   (input valid, drive_first, drive_second, bytes_valid, phase_error,
                   output ready);
endinterface

### hdl/epd_encode.sv
// Combinational drive-code encoder for one registered pixel item.
module epd_encode
   import epd_pkg::*;
(
   input  req_payload_type req,
   output rsp_payload_type rsp
);

   function automatic logic [1:0] pixel_code(input logic [2:0] mode,
                                             input logic new_bit,
                                             input logic old_bit);
      logic [1:0] code;
      code = CODE_DISCHARGE;
      case (mode)
         MODE_BLACK:   code = new_bit ? CODE_BLACK : CODE_HOLD;
         MODE_BW:      code = new_bit ? CODE_BLACK : CODE_WHITE;
         MODE_PARTIAL: begin
            if (old_bit && !new_bit) code = CODE_WHITE;
            else if (!old_bit && new_bit) code = CODE_BLACK;
            else code = CODE_HOLD;
         end
         default:      code = CODE_DISCHARGE;
      endcase
      return code;
   endfunction

   logic       phase_bad;
   logic [3:0] phase_idx;
   logic [7:0] mono_first;
   logic [7:0] mono_second;
   logic [7:0] gray_byte;

   assign phase_bad = req.phase > LAST_PHASE;
   // Out-of-range phases never reach the table.
   assign phase_idx = phase_bad ? '0 : req.phase;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         mono_first[2*b +: 2]  = pixel_code(req.mode, req.first_byte[4+b],
                                            req.second_byte[4+b]);
         mono_second[2*b +: 2] = pixel_code(req.mode, req.first_byte[b],
                                            req.second_byte[b]);
      end
   end

   // Low pixel of each byte sits above its high pixel in the output nibble.
   assign gray_byte = {GRAY_WAVE[req.second_byte[2:0]][phase_idx],
                       GRAY_WAVE[req.second_byte[6:4]][phase_idx],
                       GRAY_WAVE[req.first_byte[2:0]][phase_idx],
                       GRAY_WAVE[req.first_byte[6:4]][phase_idx]};

   always_comb begin
      unique case (req.mode)
         MODE_GRAY: begin
            rsp.drive_first  = phase_bad ? 8'h00 : gray_byte;
            rsp.drive_second = 8'h00;
            rsp.bytes_valid  = COUNT_ONE;
            rsp.phase_error  = phase_bad;
         end
         MODE_BLACK, MODE_BW, MODE_PARTIAL: begin
            rsp.drive_first  = mono_first;
            rsp.drive_second = mono_second;
            rsp.bytes_valid  = COUNT_TWO;
            rsp.phase_error  = 1'b0;
         end
         default: begin
            rsp.drive_first  = 8'h00;
            rsp.drive_second = 8'h00;
            rsp.bytes_valid  = COUNT_TWO;
            rsp.phase_error  = 1'b0;
         end
      endcase
   end

endmodule

### hdl/eink_pixel_drive_encoder.sv
// Top level of the e-paper pixel drive encoder: input register, encoder, result register.
//
// Usage: frame-buffer bytes arrive on req_chan, one transfer per item, with a mode,
// a first (new) byte, a second (old or second gray pair) byte and a waveform phase.
// Each item yields exactly one transfer on rsp_chan carrying two drive bytes (high
// nibble codes first, then low nibble codes), the count of meaningful drive bytes
// and a phase error flag for grayscale items whose phase lies above 8.
// A request passes through the input register, then through the encoder into the
// result register, before it is offered as a valid response.
// Throughput is one item per clock while rsp_chan is not stalled; the encoder is a
// single pass of table lookups and code selection between the two registers.
// When the receiver stalls, the result register holds its transfer and the input
// register takes one more item; req_chan.ready then falls until rsp_chan moves.
// req_chan.ready follows rsp_chan.ready combinationally through the two stages.
// Synchronous reset empties both stages; payload contents are left as they are.
module eink_pixel_drive_encoder
   import epd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   epd_req_if.sink         req_chan,
   epd_rsp_if.source       rsp_chan
);

   req_payload_type stage_ff;
   req_payload_type stage_in;
   logic            stage_valid_ff;
   rsp_payload_type result_ff;
   rsp_payload_type result_in;
   logic            result_valid_ff;
   logic            result_load;
   logic            stage_load;

   // The result register takes a new item whenever it is empty or being drained.
   assign result_load = !result_valid_ff || rsp_chan.ready;
   // The input register accepts when empty or when its item moves on this cycle.
   assign req_chan.ready = !stage_valid_ff || result_load;
   assign stage_load = req_chan.valid && req_chan.ready;

   assign stage_in = '{mode:        req_chan.mode,
                       first_byte:  req_chan.first_byte,
                       second_byte: req_chan.second_byte,
                       phase:       req_chan.phase};

   epd_encode u_encode (
      .req (stage_ff),
      .rsp (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) stage_valid_ff <= req_chan.valid;
         if (result_load) result_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) stage_ff <= stage_in;
      if (result_load && stage_valid_ff) result_ff <= result_in;
   end

   assign rsp_chan.valid        = result_valid_ff;
   assign rsp_chan.drive_first  = result_ff.drive_first;
   assign rsp_chan.drive_second = result_ff.drive_second;
   assign rsp_chan.bytes_valid  = result_ff.bytes_valid;
   assign rsp_chan.phase_error  = result_ff.phase_error;

endmodule

### hdl/epd_checker.sv
// Port-level checks for the e-paper drive encoder, bound to its top level.
module epd_checker
   import epd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] drive_first,
   input logic [7:0] drive_second,
   input logic [1:0] bytes_valid,
   input logic       phase_error
);

   // A reset leaves no response pending.
   reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response keeps its contents.
   stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drive_first)
         && $stable(drive_second) && $stable(bytes_valid) && $stable(phase_error))
      else $error("stalled response changed");

   // A phase error only comes with a single zero drive byte.
   error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && phase_error |-> bytes_valid == COUNT_ONE
         && drive_first == 8'h00 && drive_second == 8'h00)
      else $error("phase error with nonzero drive data");

   // Each response carries two bytes, or one byte and an empty second byte.
   single_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (bytes_valid == COUNT_TWO)
         || (bytes_valid == COUNT_ONE && drive_second == 8'h00))
      else $error("bad byte count or stray second byte");

endmodule

bind eink_pixel_drive_encoder epd_checker u_epd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .drive_first  (rsp_chan.drive_first),
   .drive_second (rsp_chan.drive_second),
   .bytes_valid  (rsp_chan.bytes_valid),
   .phase_error  (rsp_chan.phase_error)
);
